/* rtl/ttso_pkg.sv */
// Package with shared types, constants and the quarter-wave sine table.
`timescale 1ns / 1ps

package ttso_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int CHANNELS    = 2;
  localparam int PHASE_W     = 24;
  localparam int LVL_W       = 24;
  localparam int MUL_W       = 24;
  localparam int THR_W       = 23;
  localparam int STEP_W      = 23;
  localparam int GAIN_W      = 17;
  localparam int COEF_W      = 16;
  localparam int COEFS_W     = 64;

  localparam int SINE_LOG2   = 8;
  localparam int SINE_DEPTH  = 1 << SINE_LOG2;
  localparam int TIDX_W      = SINE_LOG2 + 1;
  localparam int SINE_W      = SAMPLE_BITS - 1;

  localparam logic [LVL_W-1:0] LEVEL_ONE = LVL_W'(1) << 22;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFFS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX       = 3'd5;

  localparam logic [THR_W-1:0]   RST_THRESHOLD = 23'd528000;
  localparam logic [COEFS_W-1:0] RST_COEFFS    = 64'd0;
  localparam logic [STEP_W-1:0]  RST_ATTACK    = 23'd43690;
  localparam logic [STEP_W-1:0]  RST_DECAY     = 23'd437;
  localparam logic [PHASE_W-1:0] RST_PHASE     = 24'd19223;
  localparam logic [GAIN_W-1:0]  RST_MIX       = 17'd32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FAST,
    ST_SLOW,
    ST_TRIG,
    ST_ARM,
    ST_SINE,
    ST_SCALE,
    ST_MIX
  } seq_state_e;

  typedef enum logic {
    SH_16,
    SH_22
  } mul_shift_e;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic fast;
    logic slow;
    logic trig;
    logic arm;
    logic sine;
    logic scale;
    logic mix;
  } ctrl_t;

  localparam logic [63:0] POLY_C [6] = '{
    64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172272, 64'd3864
  };

  typedef logic [SINE_W-1:0] sine_tab_t [SINE_DEPTH+1];

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] v;
    logic [63:0] smax;
    smax = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      u  = 64'(k) << (30 - SINE_LOG2);
      u2 = (u * u) >> 30;
      p  = POLY_C[5];
      for (int i = 4; i >= 0; i--) begin
        p = POLY_C[i] - ((p * u2) >> 30);
      end
      s = (p * u) >> 30;
      v = (s * smax + (64'd1 << 29)) >> 30;
      if (v > smax) begin
        v = smax;
      end
      tab[k] = v[SINE_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

/* rtl/ttso_in_if.sv */
// Input channel interface carrying one channel-tagged sample word.
`timescale 1ns / 1ps

interface ttso_in_if;
  logic                               valid;
  logic                               ready;
  logic                               channel;
  logic signed [ttso_pkg::SAMPLE_BITS-1:0] dry_sample;

  modport source (output valid, output channel, output dry_sample, input ready);
  modport sink (input valid, input channel, input dry_sample, output ready);
endinterface

/* rtl/ttso_out_if.sv */
// Output channel interface carrying one processed sample word.
`timescale 1ns / 1ps

interface ttso_out_if;
  logic                               valid;
  logic                               ready;
  logic                               out_channel;
  logic signed [ttso_pkg::SAMPLE_BITS-1:0] wet_sample;
  logic                               fired;

  modport source (output valid, output out_channel, output wet_sample, output fired,
                  input ready);
  modport sink (input valid, input out_channel, input wet_sample, input fired,
                output ready);
endinterface

/* rtl/ttso_mul.sv */
// Shared registered multiplier with a selectable right shift of the product.
`timescale 1ns / 1ps

module ttso_mul (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [ttso_pkg::MUL_W-1:0]    a_i,
  input  logic [ttso_pkg::MUL_W-1:0]    b_i,
  input  ttso_pkg::mul_shift_e          sh_i,
  output logic [ttso_pkg::MUL_W-1:0]    res_o
);

  logic [2*ttso_pkg::MUL_W-1:0] prod;
  logic [2*ttso_pkg::MUL_W-1:0] shifted;
  logic [ttso_pkg::MUL_W-1:0]   res_q;

  always_comb begin
    prod = a_i * b_i;
    case (sh_i)
      ttso_pkg::SH_22: shifted = prod >> 22;
      ttso_pkg::SH_16: shifted = prod >> 16;
      default:         shifted = prod >> 16;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= shifted[ttso_pkg::MUL_W-1:0];
    end
  end

  assign res_o = res_q;

endmodule

/* rtl/ttso_ctrl.sv */
// Sequencer that steps one sample through the shared multiplier.
`timescale 1ns / 1ps

module ttso_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_free_i,
  output ttso_pkg::ctrl_t ctrl_o
);

  ttso_pkg::seq_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ttso_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ttso_pkg::ST_FAST;
        end
      end
      ttso_pkg::ST_FAST:  state_d = ttso_pkg::ST_SLOW;
      ttso_pkg::ST_SLOW:  state_d = ttso_pkg::ST_TRIG;
      ttso_pkg::ST_TRIG:  state_d = ttso_pkg::ST_ARM;
      ttso_pkg::ST_ARM:   state_d = ttso_pkg::ST_SINE;
      ttso_pkg::ST_SINE:  state_d = ttso_pkg::ST_SCALE;
      ttso_pkg::ST_SCALE: state_d = ttso_pkg::ST_MIX;
      ttso_pkg::ST_MIX: begin
        if (out_free_i) begin
          state_d = ttso_pkg::ST_IDLE;
        end
      end
      default: state_d = ttso_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      ttso_pkg::ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        ctrl_o.load     = in_valid_i;
      end
      ttso_pkg::ST_FAST:  ctrl_o.fast  = 1'b1;
      ttso_pkg::ST_SLOW:  ctrl_o.slow  = 1'b1;
      ttso_pkg::ST_TRIG:  ctrl_o.trig  = 1'b1;
      ttso_pkg::ST_ARM:   ctrl_o.arm   = 1'b1;
      ttso_pkg::ST_SINE:  ctrl_o.sine  = 1'b1;
      ttso_pkg::ST_SCALE: ctrl_o.scale = 1'b1;
      ttso_pkg::ST_MIX:   ctrl_o.mix   = out_free_i;
      default:            ctrl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttso_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/transient_triggered_sub_oscillator.sv */
// Top level of the transient-triggered sub oscillator.
`timescale 1ns / 1ps

// Each sample word goes from the accept state to its result register through seven
// sequencer steps that share a single 24x24 multiplier for the fast and slow envelope
// updates, the sine scaling and the mix gain, with the trigger and level updates in
// between. A new word can be accepted in the cycle after the result is registered, so
// the block takes no new word while one is in flight; a stalled output holds the last
// step until its register is free. Configuration writes take effect at once and are
// meant to happen only while the block is idle.
module transient_triggered_sub_oscillator #(
  parameter int CHANNELS = ttso_pkg::CHANNELS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  ttso_in_if.sink                             in_if,
  ttso_out_if.source                          out_if,
  input  logic                                cfg_we_i,
  input  logic [ttso_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ttso_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int S    = ttso_pkg::SAMPLE_BITS;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [S+1:0] SMAX = (S+2)'((64'd1 << (S - 1)) - 64'd1);
  localparam logic signed [S+1:0] SMIN = -SMAX - (S+2)'(1);

  // Configuration registers.
  logic [ttso_pkg::THR_W-1:0]   thr_q;
  logic [ttso_pkg::COEFS_W-1:0] coefs_q;
  logic [ttso_pkg::STEP_W-1:0]  attack_q;
  logic [ttso_pkg::STEP_W-1:0]  decay_q;
  logic [ttso_pkg::PHASE_W-1:0] pstep_q;
  logic [ttso_pkg::GAIN_W-1:0]  mix_q;

  // Per-channel state.
  logic [S-1:0]                 fast_q  [CHANNELS];
  logic [S-1:0]                 slow_q  [CHANNELS];
  logic                         dis_q   [CHANNELS];
  logic [ttso_pkg::PHASE_W-1:0] phase_q [CHANNELS];
  logic [ttso_pkg::LVL_W-1:0]   lvl_q   [CHANNELS];

  // Working registers for the word in flight.
  logic                         ch_q;
  logic [CH_W-1:0]              cidx_q;
  logic                         live_q;
  logic signed [S-1:0]          dry_q;
  logic [S-1:0]                 mag_q;
  logic [S-1:0]                 fast_w_q;
  logic [S-1:0]                 slow_w_q;
  logic                         fup_q;
  logic                         sup_q;
  logic                         dis_w_q;
  logic [ttso_pkg::PHASE_W-1:0] phase_w_q;
  logic [ttso_pkg::LVL_W-1:0]   lvl_w_q;
  logic                         fired_q;
  logic                         rum_on_q;
  logic                         neg_q;

  // Result register.
  logic                         out_valid_q;
  logic                         out_ch_q;
  logic signed [S-1:0]          wet_q;
  logic                         out_fired_q;

  ttso_pkg::ctrl_t              ctrl;
  logic                         out_free;
  logic                         in_live;
  logic [CH_W-1:0]              in_cidx;
  logic [S-1:0]                 in_mag;

  logic                         fast_up;
  logic                         slow_up;
  logic [S-1:0]                 fdelta;
  logic [S-1:0]                 sdelta;
  logic signed [S:0]            diff;
  logic signed [S+1:0]          diff2;
  logic signed [S:0]            thr_s;
  logic signed [S+1:0]          thr_s2;
  logic                         fire;
  logic                         dis_set;
  logic                         rearm;

  logic [1:0]                   quad;
  logic [ttso_pkg::SINE_LOG2-1:0] ridx;
  logic [ttso_pkg::TIDX_W-1:0]  tidx;
  logic [ttso_pkg::SINE_W-1:0]  sine_val;
  logic                         rum_on;
  logic [ttso_pkg::LVL_W-1:0]   gain_lvl;

  logic                         mul_en;
  logic [ttso_pkg::MUL_W-1:0]   mul_a;
  logic [ttso_pkg::MUL_W-1:0]   mul_b;
  ttso_pkg::mul_shift_e         mul_sh;
  logic [ttso_pkg::MUL_W-1:0]   mul_res;

  logic signed [S:0]            rum;
  logic signed [S+1:0]          wet_sum;
  logic signed [S-1:0]          wet_sat;

  assign out_free = !out_valid_q || out_if.ready;

  ttso_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  ttso_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .sh_i  (mul_sh),
    .res_o (mul_res)
  );

  assign in_if.ready = ctrl.in_ready;

  always_comb begin
    in_live = (32'(in_if.channel) < CHANNELS);
    in_cidx = in_live ? CH_W'(in_if.channel) : '0;
    in_mag  = in_if.dry_sample[S-1] ? S'(-in_if.dry_sample) : S'(in_if.dry_sample);
  end

  always_comb begin
    fast_up = mag_q > fast_w_q;
    slow_up = mag_q > slow_w_q;
    fdelta  = fast_up ? mag_q - fast_w_q : fast_w_q - mag_q;
    sdelta  = slow_up ? mag_q - slow_w_q : slow_w_q - mag_q;
  end

  always_comb begin
    diff    = $signed({1'b0, fast_w_q}) - $signed({1'b0, slow_w_q});
    diff2   = {diff, 1'b0};
    thr_s   = $signed((S+1)'(thr_q));
    thr_s2  = $signed((S+2)'(thr_q));
    fire    = live_q && !dis_w_q && (diff > thr_s);
    dis_set = dis_w_q || fire;
    rearm   = dis_set && (diff2 < thr_s2);
  end

  always_comb begin
    quad     = phase_w_q[ttso_pkg::PHASE_W-1 -: 2];
    ridx     = phase_w_q[ttso_pkg::PHASE_W-3 -: ttso_pkg::SINE_LOG2];
    tidx     = quad[0] ? ttso_pkg::TIDX_W'(ttso_pkg::SINE_DEPTH) - {1'b0, ridx}
                       : {1'b0, ridx};
    sine_val = ttso_pkg::SINE_TAB[tidx];
    rum_on   = lvl_w_q != '0;
    gain_lvl = (lvl_w_q < ttso_pkg::LEVEL_ONE) ? lvl_w_q : ttso_pkg::LEVEL_ONE;
  end

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    mul_sh = ttso_pkg::SH_16;
    if (ctrl.fast) begin
      mul_en = 1'b1;
      mul_a  = ttso_pkg::MUL_W'(fdelta);
      mul_b  = ttso_pkg::MUL_W'(fast_up ? coefs_q[15:0] : coefs_q[31:16]);
    end else if (ctrl.slow) begin
      mul_en = 1'b1;
      mul_a  = ttso_pkg::MUL_W'(sdelta);
      mul_b  = ttso_pkg::MUL_W'(slow_up ? coefs_q[47:32] : coefs_q[63:48]);
    end else if (ctrl.sine) begin
      mul_en = 1'b1;
      mul_a  = rum_on ? ttso_pkg::MUL_W'(sine_val) : '0;
      mul_b  = ttso_pkg::MUL_W'(gain_lvl);
      mul_sh = ttso_pkg::SH_22;
    end else if (ctrl.scale) begin
      mul_en = 1'b1;
      mul_a  = live_q ? mul_res : '0;
      mul_b  = ttso_pkg::MUL_W'(mix_q);
    end
  end

  always_comb begin
    rum     = neg_q ? -$signed({1'b0, mul_res}) : $signed({1'b0, mul_res});
    wet_sum = (S+2)'(dry_q) + (S+2)'(rum);
    if (wet_sum > SMAX) begin
      wet_sat = SMAX[S-1:0];
    end else if (wet_sum < SMIN) begin
      wet_sat = SMIN[S-1:0];
    end else begin
      wet_sat = wet_sum[S-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= ttso_pkg::RST_THRESHOLD;
      coefs_q  <= ttso_pkg::RST_COEFFS;
      attack_q <= ttso_pkg::RST_ATTACK;
      decay_q  <= ttso_pkg::RST_DECAY;
      pstep_q  <= ttso_pkg::RST_PHASE;
      mix_q    <= ttso_pkg::RST_MIX;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ttso_pkg::CFG_THRESHOLD: thr_q    <= cfg_data_i[ttso_pkg::THR_W-1:0];
        ttso_pkg::CFG_COEFFS:    coefs_q  <= cfg_data_i[ttso_pkg::COEFS_W-1:0];
        ttso_pkg::CFG_ATTACK:    attack_q <= cfg_data_i[ttso_pkg::STEP_W-1:0];
        ttso_pkg::CFG_DECAY:     decay_q  <= cfg_data_i[ttso_pkg::STEP_W-1:0];
        ttso_pkg::CFG_PHASE:     pstep_q  <= cfg_data_i[ttso_pkg::PHASE_W-1:0];
        ttso_pkg::CFG_MIX:       mix_q    <= cfg_data_i[ttso_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      ch_q      <= in_if.channel;
      cidx_q    <= in_cidx;
      live_q    <= in_live;
      dry_q     <= in_if.dry_sample;
      mag_q     <= in_mag;
      fast_w_q  <= fast_q[in_cidx];
      slow_w_q  <= slow_q[in_cidx];
      dis_w_q   <= dis_q[in_cidx];
      phase_w_q <= phase_q[in_cidx];
      lvl_w_q   <= lvl_q[in_cidx];
      fired_q   <= 1'b0;
    end
    if (ctrl.fast) begin
      fup_q <= fast_up;
    end
    if (ctrl.slow) begin
      sup_q    <= slow_up;
      fast_w_q <= fup_q ? fast_w_q + mul_res : fast_w_q - mul_res;
    end
    if (ctrl.trig) begin
      slow_w_q <= sup_q ? slow_w_q + mul_res : slow_w_q - mul_res;
    end
    if (ctrl.arm) begin
      dis_w_q <= dis_set && !rearm;
      fired_q <= fire;
      if (fire) begin
        lvl_w_q   <= ttso_pkg::LVL_W'(attack_q);
        phase_w_q <= '0;
      end
    end
    if (ctrl.sine) begin
      rum_on_q <= rum_on;
      neg_q    <= quad[1];
      if (rum_on) begin
        phase_w_q <= phase_w_q + pstep_q;
        if (lvl_w_q < ttso_pkg::LEVEL_ONE) begin
          lvl_w_q <= lvl_w_q + ttso_pkg::LVL_W'(attack_q);
        end
      end
    end
    if (ctrl.scale) begin
      if (rum_on_q && (lvl_w_q >= ttso_pkg::LEVEL_ONE)) begin
        lvl_w_q <= (lvl_w_q > ttso_pkg::LVL_W'(decay_q))
                   ? lvl_w_q - ttso_pkg::LVL_W'(decay_q) : '0;
      end
    end
    if (ctrl.mix) begin
      out_ch_q    <= ch_q;
      wet_q       <= wet_sat;
      out_fired_q <= fired_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        fast_q[c]  <= '0;
        slow_q[c]  <= '0;
        dis_q[c]   <= 1'b0;
        phase_q[c] <= '0;
        lvl_q[c]   <= '0;
      end
    end else if (ctrl.mix && live_q) begin
      fast_q[cidx_q]  <= fast_w_q;
      slow_q[cidx_q]  <= slow_w_q;
      dis_q[cidx_q]   <= dis_w_q;
      phase_q[cidx_q] <= phase_w_q;
      lvl_q[cidx_q]   <= lvl_w_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.mix) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.out_channel = out_ch_q;
  assign out_if.wet_sample  = wet_q;
  assign out_if.fired       = out_fired_q;

  a_fire_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.fired) |-> (32'(out_if.out_channel) < CHANNELS))
    else $error("fired word reported for a channel without state");

  a_fire_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.mix && fired_q) |=> dis_q[cidx_q])
    else $error("channel still armed after firing");

  a_fire_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.mix |-> (!fired_q || live_q))
    else $error("fire flag set for a pass-through word");

  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("new word accepted while one is in flight");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the transient-triggered sub oscillator: random and directed words.
`timescale 1ns / 1ps

module testbench;

  localparam logic [23:0] LEVEL_FULL = 24'h400000;
  localparam logic [63:0] FULL_SCALE = 64'd8388607;
  localparam longint WET_MAX = 64'sd8388607;
  localparam longint WET_MIN = -64'sd8388608;
  localparam logic [63:0] SINE_POLY [6] = '{
    64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172272, 64'd3864
  };

  typedef struct {
    logic                                    ch;
    logic signed [ttso_pkg::SAMPLE_BITS-1:0] dry;
  } dry_word_t;

  typedef struct {
    logic                                    ch;
    logic signed [ttso_pkg::SAMPLE_BITS-1:0] wet;
    logic                                    fired;
  } wet_word_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [ttso_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [ttso_pkg::CFG_DATA_W-1:0] cfg_data;

  ttso_in_if  dry_if ();
  ttso_out_if wet_if ();

  transient_triggered_sub_oscillator uut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_if     (dry_if),
    .out_if    (wet_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // Predicted register copy and per-channel state.
  logic [22:0] thr_reg;
  logic [63:0] coeff_reg;
  logic [22:0] attack_reg;
  logic [22:0] decay_reg;
  logic [23:0] phase_step_reg;
  logic [16:0] mix_reg;
  logic [23:0] fast_env [2];
  logic [23:0] slow_env [2];
  logic        disarmed [2];
  logic [23:0] phase_acc [2];
  logic [23:0] level [2];
  logic [22:0] quarter_sine [257];

  dry_word_t   dry_pending [$];
  wet_word_t   wet_expected [$];
  dry_word_t   next_word;
  wet_word_t   want_word;
  bit          loud_ch [2];
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int          words_queued;
  int          words_accepted;
  int          words_checked;
  int          fires_seen;
  int          mismatches;

  function automatic logic [23:0] follow_env(input logic [23:0] env, input logic [23:0] mag,
                                             input logic [15:0] c_up, input logic [15:0] c_dn);
    logic [63:0] e;
    logic [63:0] m;
    logic [63:0] step;
    e = 64'(env);
    m = 64'(mag);
    if (m > e) begin
      step = (64'(c_up) * (m - e)) >> 16;
      return 24'(e + step);
    end
    step = (64'(c_dn) * (e - m)) >> 16;
    return 24'(e - step);
  endfunction

  function automatic longint scale_toward_zero(input longint x, input longint unsigned g,
                                               input int sh);
    longint unsigned m;
    longint unsigned r;
    m = (x < 0) ? -x : x;
    r = (m * g) >> sh;
    return (x < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic wet_word_t predict_wet_word(input logic ch,
      input logic signed [ttso_pkg::SAMPLE_BITS-1:0] dry);
    wet_word_t   w;
    logic [23:0] mag;
    logic [23:0] lvl;
    logic [9:0]  idx;
    logic [22:0] tab;
    longint      diff;
    longint      rumble;
    longint      sum;
    w.fired = 1'b0;
    mag = dry[23] ? ~dry + 24'd1 : dry;
    fast_env[ch] = follow_env(fast_env[ch], mag, coeff_reg[15:0], coeff_reg[31:16]);
    slow_env[ch] = follow_env(slow_env[ch], mag, coeff_reg[47:32], coeff_reg[63:48]);
    diff = longint'(fast_env[ch]) - longint'(slow_env[ch]);
    if (!disarmed[ch] && diff > longint'(thr_reg)) begin
      disarmed[ch] = 1'b1;
      level[ch] = {1'b0, attack_reg};
      phase_acc[ch] = '0;
      w.fired = 1'b1;
    end
    if (disarmed[ch] && 2 * diff < longint'(thr_reg)) begin
      disarmed[ch] = 1'b0;
    end
    rumble = 0;
    lvl = level[ch];
    if (lvl != '0) begin
      idx = phase_acc[ch][23:14];
      tab = idx[8] ? quarter_sine[256 - idx[7:0]] : quarter_sine[idx[7:0]];
      rumble = scale_toward_zero(idx[9] ? -longint'(tab) : longint'(tab),
                                 (lvl < LEVEL_FULL) ? lvl : LEVEL_FULL, 22);
      phase_acc[ch] = phase_acc[ch] + phase_step_reg;
      if (lvl < LEVEL_FULL) begin
        lvl = lvl + attack_reg;
      end
      if (lvl >= LEVEL_FULL) begin
        lvl = (lvl > decay_reg) ? lvl - decay_reg : '0;
      end
      level[ch] = lvl;
    end
    rumble = scale_toward_zero(rumble, mix_reg, 16);
    sum = longint'(dry) + rumble;
    if (sum > WET_MAX) begin
      sum = WET_MAX;
    end
    if (sum < WET_MIN) begin
      sum = WET_MIN;
    end
    w.ch = ch;
    w.wet = sum[23:0];
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic queue_word(input logic ch,
                            input logic signed [ttso_pkg::SAMPLE_BITS-1:0] dry);
    dry_word_t d;
    d.ch = ch;
    d.dry = dry;
    dry_pending.insert(dry_pending.size(), d);
    words_queued++;
  endtask

  // Mostly quiet and loud stretches per channel, so that transients fire, with some noise.
  task automatic queue_random(input int count);
    logic                                    ch;
    logic [23:0]                             mag;
    logic signed [ttso_pkg::SAMPLE_BITS-1:0] dry;
    for (int n = 0; n < count; n++) begin
      ch = 1'($urandom_range(1));
      if ($urandom_range(99) < 10) begin
        dry = 24'($urandom());
      end else begin
        if ($urandom_range(11) == 0) begin
          loud_ch[ch] = !loud_ch[ch];
        end
        mag = loud_ch[ch] ? 24'($urandom_range(8388607, 2097152)) : 24'($urandom_range(16384));
        dry = ($urandom_range(1) != 0) ? -$signed(mag) : $signed(mag);
      end
      queue_word(ch, dry);
    end
  endtask

  task automatic wait_idle();
    while (words_accepted != words_queued || wet_expected.size() != 0) begin
      @(negedge clk);
    end
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ttso_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      ttso_pkg::CFG_THRESHOLD: thr_reg = data[22:0];
      ttso_pkg::CFG_COEFFS:    coeff_reg = data;
      ttso_pkg::CFG_ATTACK:    attack_reg = data[22:0];
      ttso_pkg::CFG_DECAY:     decay_reg = data[22:0];
      ttso_pkg::CFG_PHASE:     phase_step_reg = data[23:0];
      ttso_pkg::CFG_MIX:       mix_reg = data[16:0];
      default: begin
      end
    endcase
  endtask

  task automatic load_settings(input logic [63:0] thr, input logic [63:0] coeffs,
                               input logic [63:0] atk, input logic [63:0] dec,
                               input logic [63:0] ph, input logic [63:0] mix);
    write_reg(ttso_pkg::CFG_THRESHOLD, thr);
    write_reg(ttso_pkg::CFG_COEFFS, coeffs);
    write_reg(ttso_pkg::CFG_ATTACK, atk);
    write_reg(ttso_pkg::CFG_DECAY, dec);
    write_reg(ttso_pkg::CFG_PHASE, ph);
    write_reg(ttso_pkg::CFG_MIX, mix);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (dry_if.valid && dry_if.ready) begin
        wet_expected.insert(wet_expected.size(),
                            predict_wet_word(dry_if.channel, dry_if.dry_sample));
        words_accepted++;
      end
      if (!dry_if.valid || dry_if.ready) begin
        if (dry_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_word = dry_pending.pop_front();
          dry_if.valid <= 1'b1;
          dry_if.channel <= next_word.ch;
          dry_if.dry_sample <= next_word.dry;
        end else begin
          dry_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (wet_if.valid && wet_if.ready) begin
        if (wet_expected.size() == 0) begin
          report_mismatch($sformatf("word on channel %0d with nothing expected",
                                    wet_if.out_channel));
        end else begin
          want_word = wet_expected.pop_front();
          words_checked++;
          if (wet_if.fired) begin
            fires_seen++;
          end
          if (wet_if.out_channel !== want_word.ch) begin
            report_mismatch($sformatf("out_channel %0d, expected %0d",
                                      wet_if.out_channel, want_word.ch));
          end
          if (wet_if.wet_sample !== want_word.wet) begin
            report_mismatch($sformatf("wet_sample %0d, expected %0d on channel %0d",
                                      wet_if.wet_sample, want_word.wet, want_word.ch));
          end
          if (wet_if.fired !== want_word.fired) begin
            report_mismatch($sformatf("fired %0d, expected %0d on channel %0d",
                                      wet_if.fired, want_word.fired, want_word.ch));
          end
        end
      end
      wet_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  initial begin
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] v;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    dry_if.valid = 1'b0;
    dry_if.channel = 1'b0;
    dry_if.dry_sample = '0;
    wet_if.ready = 1'b0;
    words_queued = 0;
    words_accepted = 0;
    words_checked = 0;
    fires_seen = 0;
    mismatches = 0;
    for (int k = 0; k <= 256; k++) begin
      u = 64'(k) << 22;
      u2 = (u * u) >> 30;
      p = SINE_POLY[5];
      for (int i = 4; i >= 0; i--) begin
        p = SINE_POLY[i] - ((p * u2) >> 30);
      end
      s = (p * u) >> 30;
      v = (s * FULL_SCALE + (64'd1 << 29)) >> 30;
      if (v > FULL_SCALE) begin
        v = FULL_SCALE;
      end
      quarter_sine[k] = v[22:0];
    end
    thr_reg = 23'd528000;
    coeff_reg = 64'd0;
    attack_reg = 23'd43690;
    decay_reg = 23'd437;
    phase_step_reg = 24'd19223;
    mix_reg = 17'd32768;
    for (int c = 0; c < 2; c++) begin
      fast_env[c] = '0;
      slow_env[c] = '0;
      disarmed[c] = 1'b0;
      phase_acc[c] = '0;
      level[c] = '0;
      loud_ch[c] = 1'b0;
    end
    sender_idle_pct = 27;
    receiver_idle_pct = 80;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings have zero follower coefficients, so nothing can fire here.
    queue_word(1'b0, 24'sd0);
    queue_word(1'b1, 24'sd8388607);
    queue_word(1'b0, -24'sd8388608);
    queue_word(1'b1, -24'sd1);
    wait_idle();

    load_settings(64'd528000, 64'h0100_0400_8000_C000, 64'd43690, 64'd437, 64'd19223,
                  64'd65536);
    queue_word(1'b0, 24'sd0);
    queue_word(1'b0, 24'sd8388607);
    for (int n = 0; n < 6; n++) begin
      queue_word(1'b0, 24'sd0);
    end
    // The channel has re-armed by now, so this fires again while the rumble still rings.
    queue_word(1'b0, 24'sd8388607);
    queue_word(1'b0, -24'sd8388608);
    queue_word(1'b1, 24'sd1);
    queue_word(1'b1, -24'sd1);
    queue_word(1'b1, -24'sd8388608);
    queue_word(1'b1, 24'sd4194304);
    queue_word(1'b1, -24'sd4194304);
    queue_word(1'b1, 24'sd8388607);
    queue_word(1'b1, 24'sd0);
    wait_idle();

    load_settings(64'd528000, 64'h0080_0200_1000_C000, 64'd43690, 64'd437, 64'd19223,
                  64'd65536);
    queue_random(150);
    wait_idle();

    load_settings(64'd0, 64'h0400_0800_FFFF_8000, 64'd4194304, 64'd8388607, 64'd16777215,
                  64'd131071);
    queue_random(150);
    wait_idle();

    sender_idle_pct = 80;
    receiver_idle_pct = 27;
    load_settings(64'd8388607, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 64'd1, 64'd1, 64'd65536);
    queue_random(150);
    wait_idle();

    load_settings(64'd400000, 64'h0100_0400_4000_FFFF, 64'd0, 64'd0, 64'd0, 64'd65536);
    queue_random(150);
    wait_idle();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    load_settings(64'd528000, 64'h0100_0200_2000_E000, 64'd8388607, 64'd0, 64'd700000,
                  64'd98304);
    queue_random(150);
    wait_idle();

    load_settings(64'd200000, 64'h0200_0100_6000_A000, 64'd2000, 64'd100, 64'd123457, 64'd0);
    queue_random(150);
    wait_idle();

    $display("Checked %0d wet words on both channels across eight register settings.",
             words_checked);
    $display("Trigger flag seen on %0d of them; %0d mismatches.", fires_seen, mismatches);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ttso_pkg.sv
rtl/ttso_in_if.sv
rtl/ttso_out_if.sv
rtl/ttso_mul.sv
rtl/ttso_ctrl.sv
rtl/transient_triggered_sub_oscillator.sv
sim/testbench.sv
